// ----- hdl/multi_sensor_frame_collator_core_macros.svh -----
// assertion macros shared by the collator rtl
`ifndef MULTI_SENSOR_FRAME_COLLATOR_CORE_MACROS_SVH
`define MULTI_SENSOR_FRAME_COLLATOR_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define MSFC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define MSFC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/msfc_pkg.sv -----
// shared types and constants of the frame collator
`default_nettype none

package msfc_pkg;

	localparam int unsigned MAX_SLOTS  = 4;
	localparam int unsigned IDX_W      = 2;
	localparam int unsigned TAG_W      = 32;
	localparam int unsigned TIME_W     = 63;
	localparam int unsigned LAT_W      = 32;
	localparam int unsigned FILL_W     = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QDEPTH     = 2;

	localparam logic [LAT_W-1:0] RESET_PERIOD = 32'd100000000;

	// input commands
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALIGNED_MODE  = 3'd0,
		CFG_SET_PERIOD    = 3'd1,
		CFG_LATENCY_ZERO  = 3'd2,
		CFG_LATENCY_ONE   = 3'd3,
		CFG_LATENCY_TWO   = 3'd4,
		CFG_LATENCY_THREE = 3'd5
	} cfg_index_t;

	// one closed set as handed from front to back
	typedef struct packed {
		logic [MAX_SLOTS-1:0][TAG_W-1:0] tag;
		logic [MAX_SLOTS-1:0]            present;
		logic                            by_next;
	} set_rec_t;

	// set write into the queue
	typedef struct packed {
		logic     valid;
		set_rec_t rec;
	} set_push_t;

endpackage

`default_nettype wire

// ----- hdl/multi_sensor_frame_collator_core.sv -----
// Multi-sensor frame collator, top level.
//
// Input queue port: push/full. A beat carries command (frame or flush),
// sensor_id, frame_time and frame_tag. Frames are grouped into sets with
// one slot per sensor; a set closes on a time window, a repeated sensor, all
// slots filled, or a flush of a non-empty set.
// Result queue port: empty/pop. A closed set comes out as NUM_SENSORS beats in
// slot order, last_of_set marks the final one.
// Config port: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no work is in flight.
// Throughput: one input beat per cycle while full is low, one result beat per
// cycle while the reader pops. The window compare is combinational and the set
// state is registered as a beat is taken, so the next beat sees it. With the
// back part idle, a closed set goes into the set queue, then into the back
// part's set register, then into the result register. Two closed sets can wait
// between front and back; with both entries taken full is high, so a stalled
// reader holds off input after roughly two sets plus the one being walked out.
// Reset: config returns to defaults, the open set and all queues are dropped.
`default_nettype none
`include "multi_sensor_frame_collator_core_macros.svh"

module multi_sensor_frame_collator_core import msfc_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output      logic                  full,
	input  wire logic                  command,
	input  wire logic [IDX_W-1:0]      sensor_id,
	input  wire logic [TIME_W-1:0]     frame_time,
	input  wire logic [TAG_W-1:0]      frame_tag,
	output      logic                  empty,
	input  wire logic                  pop,
	output      logic [IDX_W-1:0]      slot_number,
	output      logic                  slot_present,
	output      logic [TAG_W-1:0]      slot_tag,
	output      logic                  closed_by_next,
	output      logic                  last_of_set,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	set_push_t emit;
	set_rec_t  q_rd;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;

	assign full = q_full;

	// classify beats and keep the open set
	msfc_front #(
		.NUM_SENSORS(NUM_SENSORS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.command      (command),
		.sensor_id    (sensor_id),
		.frame_time   (frame_time),
		.frame_tag    (frame_tag),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.emit         (emit)
	);

	// closed sets waiting for the back part
	msfc_setq u_setq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (emit),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// serialize sets into slot results
	msfc_back #(
		.NUM_SENSORS(NUM_SENSORS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_rd           (q_rd),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.slot_number    (slot_number),
		.slot_present   (slot_present),
		.slot_tag       (slot_tag),
		.closed_by_next (closed_by_next),
		.last_of_set    (last_of_set)
	);

	// checks
	`MSFC_ASSERT_NOW(a_no_push_when_full, emit.valid, !q_full, "set emitted into a full queue")
	`MSFC_ASSERT_NOW(a_last_slot, (!empty && last_of_set), (slot_number == IDX_W'(NUM_SENSORS - 1)), "last_of_set on wrong slot")
	`MSFC_ASSERT_NOW(a_absent_tag_zero, (!empty && !slot_present), (slot_tag == '0), "absent slot with nonzero tag")
	`MSFC_ASSERT_NEXT(a_slot_walk, (!empty && pop && !last_of_set), (!empty && slot_number == IDX_W'($past(slot_number) + 2'd1)), "slot results not contiguous")

endmodule

`default_nettype wire

// ----- hdl/msfc_front.sv -----
// front part: config registers, set state and close decision per beat
`default_nettype none

module msfc_front import msfc_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  q_full,
	input  wire logic                  command,
	input  wire logic [IDX_W-1:0]      sensor_id,
	input  wire logic [TIME_W-1:0]     frame_time,
	input  wire logic [TAG_W-1:0]      frame_tag,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output      set_push_t             emit
);

	localparam int unsigned SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	// configuration
	logic                        aligned_q;
	logic [LAT_W-1:0]            period_q;
	logic [MAX_SLOTS-1:0][LAT_W-1:0] lat_q;

	// set state
	logic [NUM_SENSORS-1:0]            slot_valid_q;
	logic [NUM_SENSORS-1:0][TAG_W-1:0] slot_tag_q;
	logic                              open_q;
	logic [TIME_W-1:0]                 start_q;
	logic [IDX_W-1:0]                  first_q;
	logic [FILL_W-1:0]                 fill_q;

	logic [NUM_SENSORS-1:0]            nxt_valid;
	logic [NUM_SENSORS-1:0][TAG_W-1:0] nxt_tag;
	logic                              nxt_open;
	logic [TIME_W-1:0]                 nxt_start;
	logic [IDX_W-1:0]                  nxt_first;
	logic [FILL_W-1:0]                 nxt_fill;

	logic [NUM_SENSORS-1:0]            filled_valid;
	logic [NUM_SENSORS-1:0][TAG_W-1:0] filled_tag;
	logic [MAX_SLOTS-1:0]              cur_present, fil_present;
	logic [MAX_SLOTS-1:0][TAG_W-1:0]   cur_tag, fil_tag;

	logic                 acc;
	logic                 in_range;
	logic [SW-1:0]        idx;
	logic [TIME_W:0]      tmo_sum;
	logic                 tmo_hit;
	logic [TIME_W+1:0]    lhs, rhs;
	logic                 algn_hit;
	logic                 close;
	logic [FILL_W-1:0]    fill_sum;

	assign cfg_ready = 1'b1;
	assign acc       = push && !q_full;
	assign in_range  = ({1'b0, sensor_id} < (IDX_W+1)'(NUM_SENSORS));
	assign idx       = sensor_id[SW-1:0];

	// window checks
	assign tmo_sum  = {1'b0, start_q} + {{(TIME_W+1-LAT_W){1'b0}}, period_q};
	assign tmo_hit  = ({1'b0, frame_time} >= tmo_sum);
	assign lhs      = {2'b00, frame_time} + {{(TIME_W+2-LAT_W){1'b0}}, lat_q[first_q]};
	assign rhs      = {2'b00, start_q}
	                + {{(TIME_W+2-LAT_W){1'b0}}, lat_q[sensor_id]}
	                + {{(TIME_W+3-LAT_W){1'b0}}, period_q[LAT_W-1:1]};
	assign algn_hit = (lhs > rhs);

	// slot arrays with the offered frame written in
	always_comb begin
		filled_valid      = slot_valid_q;
		filled_tag        = slot_tag_q;
		filled_valid[idx] = 1'b1;
		filled_tag[idx]   = frame_tag;
	end

	// widen the slot arrays to record format
	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_rec
		if (g < NUM_SENSORS) begin : g_used
			assign cur_present[g] = slot_valid_q[g];
			assign cur_tag[g]     = slot_tag_q[g];
			assign fil_present[g] = filled_valid[g];
			assign fil_tag[g]     = filled_tag[g];
		end else begin : g_unused
			assign cur_present[g] = 1'b0;
			assign cur_tag[g]     = '0;
			assign fil_present[g] = 1'b0;
			assign fil_tag[g]     = '0;
		end
	end

	// next set state and set emission
	always_comb begin
		nxt_valid            = slot_valid_q;
		nxt_tag              = slot_tag_q;
		nxt_open             = open_q;
		nxt_start            = start_q;
		nxt_first            = first_q;
		nxt_fill             = fill_q;
		close                = 1'b0;
		fill_sum             = fill_q + FILL_W'(1);
		emit.valid           = 1'b0;
		emit.rec.present     = cur_present;
		emit.rec.tag         = cur_tag;
		emit.rec.by_next     = 1'b0;
		if (acc) begin
			if (command == CMD_FLUSH) begin
				if (fill_q != '0) begin
					emit.valid = 1'b1;
					nxt_valid  = '0;
					nxt_fill   = '0;
					nxt_open   = 1'b0;
					nxt_start  = '0;
				end
			end else if (in_range) begin
				if (!aligned_q) begin
					if (!open_q || tmo_hit) begin
						if (fill_q != '0) begin
							close = 1'b1;
						end else begin
							nxt_open  = 1'b1;
							nxt_start = frame_time;
						end
					end
				end else if (!open_q) begin
					nxt_open  = 1'b1;
					nxt_start = frame_time;
					nxt_first = sensor_id;
				end else begin
					close = algn_hit;
				end
				if (slot_valid_q[idx]) begin
					close = 1'b1;
				end
				nxt_tag = filled_tag;
				if (close) begin
					// held-back frame opens the next set
					emit.valid       = 1'b1;
					emit.rec.by_next = 1'b1;
					nxt_valid        = '0;
					nxt_valid[idx]   = 1'b1;
					nxt_open         = 1'b1;
					nxt_start        = frame_time;
					if (aligned_q) begin
						nxt_first = sensor_id;
					end
					nxt_fill = FILL_W'(1);
				end else if (fill_sum >= FILL_W'(NUM_SENSORS)) begin
					// last slot filled, set goes out complete
					emit.valid       = 1'b1;
					emit.rec.present = fil_present;
					emit.rec.tag     = fil_tag;
					nxt_valid        = '0;
					nxt_fill         = '0;
					nxt_open         = 1'b0;
					nxt_start        = '0;
				end else begin
					nxt_valid = filled_valid;
					nxt_fill  = fill_sum;
				end
			end
		end
	end

	// control state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q    <= 1'b0;
			period_q     <= RESET_PERIOD;
			lat_q        <= '0;
			slot_valid_q <= '0;
			open_q       <= 1'b0;
			start_q      <= '0;
			first_q      <= '0;
			fill_q       <= '0;
		end else begin
			slot_valid_q <= nxt_valid;
			open_q       <= nxt_open;
			start_q      <= nxt_start;
			first_q      <= nxt_first;
			fill_q       <= nxt_fill;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALIGNED_MODE:  aligned_q <= cfg_data[0];
					CFG_SET_PERIOD:    period_q  <= cfg_data;
					CFG_LATENCY_ZERO:  lat_q[0]  <= cfg_data;
					CFG_LATENCY_ONE:   lat_q[1]  <= cfg_data;
					CFG_LATENCY_TWO:   lat_q[2]  <= cfg_data;
					CFG_LATENCY_THREE: lat_q[3]  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// slot tags, read only where the slot is valid
	always_ff @(posedge clk) begin
		slot_tag_q <= nxt_tag;
	end

endmodule

`default_nettype wire

// ----- hdl/msfc_setq.sv -----
// short queue of closed sets between front and back
`default_nettype none

module msfc_setq import msfc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire set_push_t wr,
	output      logic      full,
	output      logic      empty,
	input  wire logic      pop,
	output      set_rec_t  rd
);

	localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCW = $clog2(QDEPTH + 1);

	set_rec_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr.valid && !full;
	assign do_rd = pop && !empty;
	assign rd    = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + QAW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + QAW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr.rec;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msfc_back.sv -----
// back part: walks a closed set one slot per beat into the result register
`default_nettype none

module msfc_back import msfc_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire set_rec_t         q_rd,
	output      logic             q_pop,
	output      logic             empty,
	input  wire logic             pop,
	output      logic [IDX_W-1:0] slot_number,
	output      logic             slot_present,
	output      logic [TAG_W-1:0] slot_tag,
	output      logic             closed_by_next,
	output      logic             last_of_set
);

	localparam int unsigned SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	set_rec_t          rec_q;
	logic              busy_q;
	logic [SW-1:0]     cnt_q;
	logic              res_valid_q;
	logic [IDX_W-1:0]  slot_number_q;
	logic              slot_present_q;
	logic [TAG_W-1:0]  slot_tag_q;
	logic              by_next_q;
	logic              last_q;

	logic              res_load;
	logic              last;
	logic              take;
	logic [IDX_W-1:0]  cnt2;

	assign cnt2     = IDX_W'(cnt_q);
	assign last     = (cnt_q == SW'(NUM_SENSORS - 1));
	assign res_load = busy_q && (!res_valid_q || pop);
	assign take     = !q_empty && (!busy_q || (res_load && last));
	assign q_pop    = take;

	// set walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (res_load && last) begin
				busy_q <= 1'b0;
			end else if (res_load) begin
				cnt_q <= cnt_q + SW'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// set and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			rec_q <= q_rd;
		end
		if (res_load) begin
			slot_number_q  <= cnt2;
			slot_present_q <= rec_q.present[cnt2];
			slot_tag_q     <= rec_q.present[cnt2] ? rec_q.tag[cnt2] : '0;
			by_next_q      <= rec_q.by_next;
			last_q         <= last;
		end
	end

	assign empty          = !res_valid_q;
	assign slot_number    = slot_number_q;
	assign slot_present   = slot_present_q;
	assign slot_tag       = slot_tag_q;
	assign closed_by_next = by_next_q;
	assign last_of_set    = last_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the multi-sensor frame collator
`timescale 1ns / 1ps

module testbench;
	import msfc_pkg::*;

	localparam int unsigned NUM_SENSORS = 4;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// one frame or flush beat as offered to the block
	typedef struct {
		logic              cmd;
		logic [IDX_W-1:0]  sensor;
		logic [TIME_W-1:0] stamp;
		logic [TAG_W-1:0]  tag;
	} frame_beat_t;

	// one slot beat of an emitted set
	typedef struct {
		logic [IDX_W-1:0] slot;
		logic             present;
		logic [TAG_W-1:0] tag;
		logic             by_next;
		logic             last;
	} slot_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  command = CMD_FRAME;
	logic [IDX_W-1:0]      sensor_id = '0;
	logic [TIME_W-1:0]     frame_time = '0;
	logic [TAG_W-1:0]      frame_tag = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [IDX_W-1:0]      slot_number;
	logic                  slot_present;
	logic [TAG_W-1:0]      slot_tag;
	logic                  closed_by_next;
	logic                  last_of_set;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expected slot beats
	frame_beat_t pending_frames [$];
	slot_beat_t  slot_results [$];

	// collator state as predicted
	logic              grp_valid [NUM_SENSORS] = '{default: 1'b0};
	logic [TAG_W-1:0]  grp_tag [NUM_SENSORS] = '{default: '0};
	logic              grp_open = 1'b0;
	logic [TIME_W-1:0] grp_start = '0;
	logic [IDX_W-1:0]  grp_first = '0;
	logic [FILL_W-1:0] grp_count = '0;

	// register copies as predicted
	logic             mode_aligned = 1'b0;
	logic [LAT_W-1:0] window_period = RESET_PERIOD;
	logic [LAT_W-1:0] sensor_latency [NUM_SENSORS] = '{default: '0};

	// settings used to shape the random frames of a phase
	logic [LAT_W-1:0] phase_period = RESET_PERIOD;
	logic [LAT_W-1:0] phase_latency [NUM_SENSORS] = '{default: '0};

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  free_run = 1'b0;
	bit  frame_taken = 1'b0;
	bit  slot_taken = 1'b0;

	multi_sensor_frame_collator_core #(
		.NUM_SENSORS(NUM_SENSORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.sensor_id(sensor_id),
		.frame_time(frame_time),
		.frame_tag(frame_tag),
		.empty(empty),
		.pop(pop),
		.slot_number(slot_number),
		.slot_present(slot_present),
		.slot_tag(slot_tag),
		.closed_by_next(closed_by_next),
		.last_of_set(last_of_set),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (free_run || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [TIME_W-1:0] any_time();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TIME_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at cycle %0d: %s seen 0x%0h expected 0x%0h",
				cycle_count, what, seen, want);
	endtask

	// emit the open set as one beat per slot, then clear it
	task automatic close_group(input logic by_next);
		slot_beat_t r;
		int k;
		for (k = 0; k < NUM_SENSORS; k++) begin
			r.slot = IDX_W'(k);
			r.present = grp_valid[k];
			r.tag = grp_valid[k] ? grp_tag[k] : '0;
			r.by_next = by_next;
			r.last = (k == NUM_SENSORS - 1);
			slot_results = {slot_results, r};
			grp_valid[k] = 1'b0;
		end
		grp_count = '0;
		grp_open = 1'b0;
		grp_start = '0;
	endtask

	// predict the slot beats caused by one accepted beat
	task automatic collate(input frame_beat_t b);
		logic [64:0] lhs;
		logic [64:0] rhs;
		logic shut;
		shut = 1'b0;
		if (b.cmd == CMD_FLUSH) begin
			if (grp_count > 0)
				close_group(1'b0);
			return;
		end
		if (b.sensor >= NUM_SENSORS)
			return;
		// window test of the selected mode
		if (!mode_aligned) begin
			if (!grp_open || {2'b0, b.stamp} >= {2'b0, grp_start} + window_period) begin
				if (grp_count > 0) begin
					shut = 1'b1;
				end else begin
					grp_open = 1'b1;
					grp_start = b.stamp;
				end
			end
		end else if (!grp_open) begin
			grp_open = 1'b1;
			grp_start = b.stamp;
			grp_first = b.sensor;
		end else begin
			lhs = {2'b0, b.stamp} + sensor_latency[grp_first];
			rhs = {2'b0, grp_start} + sensor_latency[b.sensor] + (window_period >> 1);
			shut = (lhs > rhs);
		end
		// a repeated sensor closes the set too
		if (!shut && grp_valid[b.sensor])
			shut = 1'b1;
		// held-back frame starts the next set
		if (shut) begin
			close_group(1'b1);
			grp_open = 1'b1;
			grp_start = b.stamp;
			if (mode_aligned)
				grp_first = b.sensor;
		end
		grp_valid[b.sensor] = 1'b1;
		grp_tag[b.sensor] = b.tag;
		grp_count = grp_count + 1'b1;
		if (!shut && grp_count >= NUM_SENSORS)
			close_group(1'b0);
	endtask

	// register write as predicted
	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_ALIGNED_MODE:  mode_aligned = data[0];
			CFG_SET_PERIOD:    window_period = data;
			CFG_LATENCY_ZERO:  sensor_latency[0] = data;
			CFG_LATENCY_ONE:   sensor_latency[1] = data;
			CFG_LATENCY_TWO:   sensor_latency[2] = data;
			CFG_LATENCY_THREE: sensor_latency[3] = data;
			default: ;
		endcase
	endtask

	// sample handshakes at the rising edge, predict and check
	always @(posedge clk) begin : monitor
		frame_beat_t seen_beat;
		slot_beat_t want;
		cycle_count <= cycle_count + 1;
		frame_taken <= arst_n && push && !full;
		slot_taken <= arst_n && pop && !empty;
		if (arst_n) begin
			if (push && !full) begin
				seen_beat.cmd = command;
				seen_beat.sensor = sensor_id;
				seen_beat.stamp = frame_time;
				seen_beat.tag = frame_tag;
				collate(seen_beat);
			end
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (pop && !empty) begin
				if (slot_results.size() == 0) begin
					report_mismatch("slot beat with none expected", slot_number, 0);
				end else begin
					want = slot_results.pop_front();
					if (slot_number !== want.slot)
						report_mismatch("slot_number", slot_number, want.slot);
					if (slot_present !== want.present)
						report_mismatch("slot_present", slot_present, want.present);
					if (slot_tag !== want.tag)
						report_mismatch("slot_tag", slot_tag, want.tag);
					if (closed_by_next !== want.by_next)
						report_mismatch("closed_by_next", closed_by_next, want.by_next);
					if (last_of_set !== want.last)
						report_mismatch("last_of_set", last_of_set, want.last);
				end
			end
		end
	end

	// frame driver: one beat held until taken, random gaps between beats
	always @(negedge clk) begin : frame_driver
		frame_beat_t b;
		if (arst_n && (!push || frame_taken)) begin
			if (send_gap > 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_frames.size() > 0) begin
				b = pending_frames.pop_front();
				push <= 1'b1;
				command <= b.cmd;
				sensor_id <= b.sensor;
				frame_time <= b.stamp;
				frame_tag <= b.tag;
				send_gap <= pick_gap();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result sink: stalls of random length after taken beats
	always @(negedge clk) begin : result_sink
		int g;
		if (recv_gap > 0) begin
			pop <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			g = slot_taken ? pick_gap() : 0;
			pop <= (g == 0);
			recv_gap <= (g == 0) ? 0 : g - 1;
		end
	end

	task automatic queue_frame(input logic cmd, input logic [IDX_W-1:0] sensor,
			input logic [TIME_W-1:0] stamp, input logic [TAG_W-1:0] tag);
		frame_beat_t b;
		b.cmd = cmd;
		b.sensor = sensor;
		b.stamp = stamp;
		b.tag = tag;
		pending_frames = {pending_frames, b};
	endtask

	// wait until all beats are in and out, then let the pipeline drain
	task automatic settle_block();
		while (pending_frames.size() != 0 || push || slot_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// write every register once the block is idle
	task automatic set_registers(input logic mode, input logic [LAT_W-1:0] period,
			input logic [LAT_W-1:0] l0, input logic [LAT_W-1:0] l1,
			input logic [LAT_W-1:0] l2, input logic [LAT_W-1:0] l3);
		settle_block();
		write_reg(CFG_UNUSED, $urandom());
		write_reg(CFG_ALIGNED_MODE, {31'd0, mode});
		write_reg(CFG_SET_PERIOD, period);
		write_reg(CFG_LATENCY_ZERO, l0);
		write_reg(CFG_LATENCY_ONE, l1);
		write_reg(CFG_LATENCY_TWO, l2);
		write_reg(CFG_LATENCY_THREE, l3);
		@(negedge clk);
		cfg_valid <= 1'b0;
		phase_period = period;
		phase_latency = '{l0, l1, l2, l3};
	endtask

	// mostly well-timed sets of shuffled sensors, with flushes, repeats and noise
	task automatic queue_random_frames(input int count);
		logic [TIME_W-1:0] base;
		logic [LAT_W-1:0] pr;
		int order [NUM_SENSORS];
		int n, r, k, j, pick, tmp;
		pr = phase_period;
		r = $urandom_range(0, 3);
		base = (r == 0) ? '0 : (r == 1) ? any_time() : TIME_W'({$urandom_range(0, 255), $urandom()});
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : NUM_SENSORS;
				for (j = 0; j < NUM_SENSORS; j++)
					order[j] = j;
				for (j = NUM_SENSORS - 1; j > 0; j--) begin
					pick = $urandom_range(0, j);
					tmp = order[j];
					order[j] = order[pick];
					order[pick] = tmp;
				end
				for (j = 0; j < k; j++)
					queue_frame(CMD_FRAME, IDX_W'(order[j]),
						base + phase_latency[order[j]] + $urandom_range(0, pr >> 2),
						$urandom());
				n += k;
				base = base + pr + $urandom_range(0, pr >> 3);
			end else if (r < 75) begin
				queue_frame(CMD_FLUSH, IDX_W'($urandom()), any_time(), $urandom());
				n++;
			end else if (r < 85) begin
				pick = $urandom_range(0, NUM_SENSORS - 1);
				queue_frame(CMD_FRAME, IDX_W'(pick), base, $urandom());
				queue_frame(CMD_FRAME, IDX_W'(pick), base + $urandom_range(0, pr >> 2),
					$urandom());
				n += 2;
			end else if (r < 92) begin
				queue_frame(CMD_FRAME, IDX_W'($urandom()), any_time(), $urandom());
				n++;
			end else begin
				base = base + pr + pr + 1;
				queue_frame(CMD_FRAME, IDX_W'($urandom()), base, $urandom());
				n++;
			end
		end
	endtask

	// reset, then the run
	initial begin : stimulus
		int ph;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// timeout mode at reset settings
		free_run = 1'b1;
		queue_frame(CMD_FRAME, 2'd0, '0, '0);
		queue_frame(CMD_FRAME, 2'd1, 63'd99999999, '1);
		queue_frame(CMD_FRAME, 2'd2, 63'd100000000, $urandom());
		queue_frame(CMD_FRAME, 2'd2, 63'd100000001, $urandom());
		queue_frame(CMD_FRAME, 2'd3, TIME_MAX, '1);
		queue_frame(CMD_FLUSH, 2'd3, any_time(), $urandom());
		queue_frame(CMD_FLUSH, 2'd0, any_time(), $urandom());
		queue_frame(CMD_FRAME, 2'd3, 63'd5, $urandom());
		queue_frame(CMD_FRAME, 2'd1, 63'd5, $urandom());
		queue_frame(CMD_FRAME, 2'd0, 63'd5, $urandom());
		queue_frame(CMD_FRAME, 2'd2, 63'd5, $urandom());

		// aligned mode, latency extremes and the exact window edge
		set_registers(1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd12345);
		queue_frame(CMD_FRAME, 2'd1, 63'd1000, $urandom());
		queue_frame(CMD_FRAME, 2'd0, 63'd1000, $urandom());
		queue_frame(CMD_FRAME, 2'd1, 63'd1000, $urandom());
		queue_frame(CMD_FRAME, 2'd2, 63'd2147484648, $urandom());
		queue_frame(CMD_FRAME, 2'd3, 63'd2147496993, $urandom());
		queue_frame(CMD_FLUSH, 2'd2, any_time(), $urandom());

		// zero period in timeout mode
		set_registers(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_frame(CMD_FRAME, 2'd0, 63'd50, $urandom());
		queue_frame(CMD_FRAME, 2'd1, 63'd49, $urandom());
		queue_frame(CMD_FRAME, 2'd2, 63'd50, $urandom());
		queue_frame(CMD_FRAME, 2'd3, '0, '0);
		queue_frame(CMD_FLUSH, 2'd1, any_time(), $urandom());

		// random phases; a set left open carries across each register change
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_registers(1'b0, 32'd1000, 32'd0, 32'd0, 32'd0, 32'd0);
				1: set_registers(1'b1, 32'd1000, $urandom_range(0, 2000),
					$urandom_range(0, 2000), $urandom_range(0, 2000),
					$urandom_range(0, 2000));
				2: set_registers(1'b0, 32'd1, $urandom(), $urandom(), $urandom(), $urandom());
				3: set_registers(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
					32'hFFFF_FFFF, 32'd0);
				4: set_registers(1'b1, 32'd1, $urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 3));
				5: set_registers(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
				6: set_registers(1'b1, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
				default: set_registers(1'b0, RESET_PERIOD, 32'd0, 32'd0, 32'd0, 32'd0);
			endcase
			free_run = (ph == 2 || ph == 5);
			queue_random_frames(55);
			if ($urandom_range(0, 1) == 1)
				queue_frame(CMD_FLUSH, IDX_W'($urandom()), any_time(), $urandom());
		end

		settle_block();
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/msfc_pkg.sv
hdl/msfc_front.sv
hdl/msfc_setq.sv
hdl/msfc_back.sv
hdl/multi_sensor_frame_collator_core.sv
tb/testbench.sv
